### rtl/dedq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the double-ended identifier queue
// no dependencies; imported by the controller, the datapath and the top level
package dedq_pkg;

   localparam int ID_W    = 31;
   localparam int COUNT_W = 9;

   typedef enum logic [1:0] {
      CMD_PUSH_BACK  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_BACK   = 2'd2,
      CMD_POP_FRONT  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   item_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    popped_id;
      logic               was_empty;
      logic               push_refused;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_out;
   } dp_ctl_type;

endpackage

### rtl/dedq_ctrl.sv
`timescale 1ns / 1ps
// sequencing for the identifier queue: takes a word, waits in the exec state for the
// registered store read, then loads the result register; depends on dedq_pkg
module dedq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dedq_pkg::dp_ctl_type ctl
);
   import dedq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctl.accept   = (state_ff == ST_IDLE) && req_valid;
      ctl.load_out = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
      state_in     = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ctl.load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // output register holds until taken, refilled when the next result is ready
      rsp_valid_in = ctl.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> (state_ff == ST_EXEC))
      else $error("accepted word did not move to exec");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |=> rsp_valid_ff)
      else $error("result load did not raise rsp_valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !ctl.load_out)
      else $error("stalled result overwritten");

endmodule

### rtl/dedq_datapath.sv
`timescale 1ns / 1ps
// ring store, front and back pointers, entry count and result register
// of the identifier queue; depends on dedq_pkg
module dedq_datapath #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dedq_pkg::dp_ctl_type ctl,
   input  dedq_pkg::req_type    req_data,
   output dedq_pkg::rsp_type    rsp_data
);
   import dedq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - 1'b1;
   endfunction

   logic [ID_W-1:0]  id_mem [QUEUE_DEPTH];
   logic [ID_W-1:0]  rd_data_ff;

   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             pop_ok_ff, pop_ok_in;
   logic             empty_ff, empty_in;
   logic             refused_ff, refused_in;
   rsp_type          rsp_ff;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [PTR_W-1:0] rd_addr;
   logic             is_full, is_empty;
   logic [CNT_W:0]   ptr_gap;

   always_comb begin
      is_full    = (count_ff == FULL_CNT);
      is_empty   = (count_ff == '0);
      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = back_ff;
      rd_addr    = front_ff;
      pop_ok_in  = 1'b0;
      empty_in   = 1'b0;
      refused_in = 1'b0;
      if (ctl.accept) begin
         unique case (req_data.cmd)
            CMD_PUSH_BACK: begin
               if (is_full) begin
                  refused_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = back_ff;
                  back_in  = ring_next(back_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_PUSH_FRONT: begin
               if (is_full) begin
                  refused_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = ring_prev(front_ff);
                  front_in = ring_prev(front_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (is_empty) begin
                  empty_in = 1'b1;
               end else begin
                  pop_ok_in = 1'b1;
                  rd_addr   = ring_prev(back_ff);
                  back_in   = ring_prev(back_ff);
                  count_in  = count_ff - 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (is_empty) begin
                  empty_in = 1'b1;
               end else begin
                  pop_ok_in = 1'b1;
                  rd_addr   = front_ff;
                  front_in  = ring_next(front_ff);
                  count_in  = count_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
      // occupied span between the pointers, for the consistency check
      if (back_ff >= front_ff) begin
         ptr_gap = (CNT_W + 1)'(back_ff - front_ff);
      end else begin
         ptr_gap = DEPTH_EXT - (CNT_W + 1)'(front_ff) + (CNT_W + 1)'(back_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // single-port store: at most one write or one registered read per accepted word
   always_ff @(posedge clock) begin
      if (wr_en) id_mem[wr_addr] <= req_data.item_id;
      if (ctl.accept && pop_ok_in) rd_data_ff <= id_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         pop_ok_ff  <= pop_ok_in;
         empty_ff   <= empty_in;
         refused_ff <= refused_in;
      end
      if (ctl.load_out) begin
         rsp_ff.popped_id    <= pop_ok_ff ? rd_data_ff : '0;
         rsp_ff.was_empty    <= empty_ff;
         rsp_ff.push_refused <= refused_ff;
         rsp_ff.entry_count  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_ptr_span: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == FULL_CNT) && (ptr_gap == '0)) ||
      (ptr_gap == (CNT_W + 1)'(count_ff)))
      else $error("pointers disagree with entry count");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> !(empty_ff && refused_ff) && !(pop_ok_ff && empty_ff))
      else $error("conflicting result flags");

endmodule

### rtl/double_ended_id_queue.sv
`timescale 1ns / 1ps
// Double-ended queue of 31-bit identifiers held in a ring store.
// Depends on dedq_pkg, dedq_ctrl and dedq_datapath.
//
// Request channel (req_valid, req_stall, req_data): each word carries a command
// (push back, push front, pop back, pop front) and an identifier used by pushes.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one word per
// request with the popped identifier, an empty-pop flag, a refused-push flag
// and the entry count after the command.
// A taken request is not followed by another until its response is loaded:
// the store's registered read port sits between the pointer update and the
// response register.
// The response register lets a new request in while an older response waits;
// if rsp_stall is still high when the next response is ready, req_stall stays
// high until the waiting word is taken.
// Reset empties the queue (pointers and count to zero); store contents are not
// cleared, and only written entries are ever read. No clearing pass is needed.
module double_ended_id_queue #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dedq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dedq_pkg::rsp_type rsp_data
);
   import dedq_pkg::*;

   dp_ctl_type ctl;

   dedq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   dedq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
